/* sv/acsc_pkg.sv */
// ----------------------------------------------------------------------------
// Alarm clock set controller package
// Shared codes, types and small arithmetic helpers for the controller.
// ----------------------------------------------------------------------------
package acsc_pkg;

  localparam int unsigned NUM_FIELDS = 3;

  localparam logic [4:0] SYM_BLANK = 5'd16;
  localparam logic [4:0] SYM_DASH  = 5'd17;

  localparam logic [5:0] HOUR_MAX   = 6'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;

  localparam logic OP_TIME = 1'b0;
  localparam logic OP_KEY  = 1'b1;

  localparam logic [1:0] FLD_HOUR = 2'd0;
  localparam logic [1:0] FLD_MIN  = 2'd1;
  localparam logic [1:0] FLD_SEC  = 2'd2;

  typedef enum logic [1:0] {
    MODE_SHOW       = 2'd0,
    MODE_EDIT_TIME  = 2'd1,
    MODE_EDIT_ALARM = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KEY_NEXT  = 2'd0,
    KEY_INC   = 2'd1,
    KEY_DONE  = 2'd2,
    KEY_ALARM = 2'd3
  } key_e;

  // Binary hour/minute/second, index 0 is the hour.
  typedef logic [NUM_FIELDS-1:0][5:0] tval_t;
  // BCD hour/minute/second as read from the clock chip.
  typedef logic [NUM_FIELDS-1:0][6:0] bcd_t;

  // State after an event, as needed to build the display.
  typedef struct packed {
    mode_e      mode;
    logic [1:0] field;
    tval_t      vals;
    bcd_t       cur_bcd;
  } view_t;

  function automatic logic [5:0] field_max(input logic [1:0] idx);
    return (idx == FLD_HOUR) ? HOUR_MAX : MINSEC_MAX;
  endfunction

  function automatic logic [6:0] bcd_value(input logic [6:0] b);
    return 7'(b[6:4]) * 7'd10 + 7'(b[3:0]);
  endfunction

  // Tens digit of a value below 64, by multiplying with 13/128.
  function automatic logic [3:0] dec_tens(input logic [5:0] v);
    logic [9:0] p;
    p = 10'(v) * 10'd13;
    return 4'(p[9:7]);
  endfunction

  function automatic logic [3:0] dec_units(input logic [5:0] v);
    logic [5:0] t;
    t = 6'(dec_tens(v)) * 6'd10;
    return 4'(v - t);
  endfunction

endpackage

/* sv/acsc_state.sv */
// ----------------------------------------------------------------------------
// Alarm clock controller state
// Mode, field select, edited and alarm times, last reading and buzzer latch,
// with the update for one event.
// ----------------------------------------------------------------------------
module acsc_state import acsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       opcode_i,
  input  logic [1:0] key_i,
  input  logic [5:0] rtc_hour_bcd_i,
  input  logic [6:0] rtc_min_bcd_i,
  input  logic [6:0] rtc_sec_bcd_i,
  output view_t      view_o,
  output logic       beep_o,
  output logic       wr_o,
  output tval_t      edit_o
);

  mode_e      mode_q, mode_d;
  logic [1:0] field_q, field_d;
  tval_t      edit_q, edit_d;
  tval_t      alarm_q, alarm_d;
  bcd_t       cur_q, cur_d;
  logic       buzz_q, buzz_d;
  logic       wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_SHOW;
      field_q <= FLD_HOUR;
      edit_q  <= '0;
      alarm_q <= '0;
      cur_q   <= '0;
      buzz_q  <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      field_q <= field_d;
      edit_q  <= edit_d;
      alarm_q <= alarm_d;
      cur_q   <= cur_d;
      buzz_q  <= buzz_d;
    end
  end

  always_comb begin
    tval_t      vals;
    tval_t      loaded;
    logic [6:0] dec;
    logic [6:0] inc_v;
    logic       match;
    logic       editing;

    mode_d  = mode_q;
    field_d = field_q;
    edit_d  = edit_q;
    alarm_d = alarm_q;
    cur_d   = cur_q;
    buzz_d  = buzz_q;
    wr      = 1'b0;
    match   = 1'b0;
    inc_v   = 7'd0;
    editing = (mode_q == MODE_EDIT_TIME) || (mode_q == MODE_EDIT_ALARM);
    vals    = (mode_q == MODE_EDIT_TIME) ? edit_q : alarm_q;

    // Last reading decoded, out-of-range values load as zero.
    for (int i = 0; i < NUM_FIELDS; i++) begin
      dec = bcd_value(cur_q[i]);
      loaded[i] = (dec > 7'(field_max(2'(i)))) ? 6'd0 : dec[5:0];
    end

    if (opcode_i == OP_TIME) begin
      cur_d[0] = 7'(rtc_hour_bcd_i);
      cur_d[1] = rtc_min_bcd_i;
      cur_d[2] = rtc_sec_bcd_i;
      match = 1'b1;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        if (bcd_value(cur_d[i]) != 7'(alarm_q[i])) begin
          match = 1'b0;
        end
      end
      if (match) begin
        buzz_d = 1'b1;
      end
    end else if (buzz_q) begin
      // A key press while the buzzer sounds only silences it.
      buzz_d = 1'b0;
    end else if (editing) begin
      case (key_i)
        KEY_NEXT: begin
          case (field_q)
            FLD_HOUR: field_d = FLD_MIN;
            FLD_MIN:  field_d = FLD_SEC;
            FLD_SEC:  field_d = FLD_HOUR;
            default:  field_d = FLD_MIN;
          endcase
        end
        KEY_INC: begin
          for (int i = 0; i < NUM_FIELDS; i++) begin
            if (field_q == 2'(i)) begin
              inc_v = 7'(vals[i]) + 7'd1;
              if (inc_v > 7'(field_max(2'(i)))) begin
                inc_v = 7'd0;
              end
              if (mode_q == MODE_EDIT_TIME) begin
                edit_d[i] = inc_v[5:0];
              end else begin
                alarm_d[i] = inc_v[5:0];
              end
            end
          end
        end
        KEY_DONE: begin
          wr      = (mode_q == MODE_EDIT_TIME);
          field_d = FLD_HOUR;
          mode_d  = MODE_SHOW;
        end
        default: ;
      endcase
    end else begin
      case (key_i)
        KEY_NEXT: begin
          mode_d = MODE_EDIT_TIME;
          edit_d = loaded;
        end
        KEY_ALARM: begin
          mode_d  = MODE_EDIT_ALARM;
          field_d = FLD_HOUR;
          edit_d  = loaded;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    view_o.mode    = mode_d;
    view_o.field   = field_d;
    view_o.vals    = (mode_d == MODE_EDIT_TIME) ? edit_d : alarm_d;
    view_o.cur_bcd = cur_d;
  end

  assign beep_o = buzz_d;
  assign wr_o   = wr;
  assign edit_o = edit_d;

endmodule

/* sv/acsc_disp.sv */
// ----------------------------------------------------------------------------
// Alarm clock display encoder
// Builds the eight display symbols HH-MM-SS from the state after an event.
// ----------------------------------------------------------------------------
module acsc_disp import acsc_pkg::*; (
  input  view_t       view_i,
  output logic [39:0] codes_o
);

  logic [7:0][4:0] sym;

  always_comb begin
    logic editing;
    logic blank;

    editing = (view_i.mode == MODE_EDIT_TIME) || (view_i.mode == MODE_EDIT_ALARM);
    // The selected field blinks off while the seconds units digit is even.
    blank   = !view_i.cur_bcd[2][0];
    sym     = '0;
    sym[2]  = SYM_DASH;
    sym[5]  = SYM_DASH;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      if (editing) begin
        if (blank && (view_i.field == 2'(i))) begin
          sym[3*i]   = SYM_BLANK;
          sym[3*i+1] = SYM_BLANK;
        end else begin
          sym[3*i]   = 5'(dec_tens(view_i.vals[i]));
          sym[3*i+1] = 5'(dec_units(view_i.vals[i]));
        end
      end else begin
        // Show mode passes the raw nibbles, invalid BCD included.
        sym[3*i]   = 5'(view_i.cur_bcd[i][6:4]);
        sym[3*i+1] = 5'(view_i.cur_bcd[i][3:0]);
      end
    end
  end

  assign codes_o = sym;

endmodule

/* sv/alarm_clock_set_controller.sv */
// ----------------------------------------------------------------------------
// Alarm clock set controller
// Takes clock readings and key presses, keeps mode, edited time, alarm and
// buzzer state, and returns one display word per event.
// ----------------------------------------------------------------------------
// Path: the input register takes the word, then the result register takes the
// update once the result register is empty or being drained.
// Throughput: one word per cycle while the output accepts, the input register is
// refilled while the result register is being drained.
// Reset: asynchronous, active low; show mode, hour field, all times zero,
// buzzer off, both stages empty.
// ----------------------------------------------------------------------------
module alarm_clock_set_controller import acsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] key, [7:2] rtc_hour_bcd, [14:8] rtc_min_bcd, [21:15] rtc_sec_bcd
  input  logic [23:0] s_axis_tdata_i,
  // [0] opcode
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [39:0] display_codes, [40] beep, [45:41] new_hour, [51:46] new_min,
  // [57:52] new_sec
  output logic [63:0] m_axis_tdata_o,
  // [0] write_time
  output logic        m_axis_tuser_o
);

  logic        in_valid_q;
  logic        in_op_q;
  logic [23:0] in_data_q;
  logic        out_valid_q;
  logic [63:0] out_data_q, out_data_d;
  logic        out_wr_q;
  logic        adv;

  view_t       view;
  logic        beep;
  logic        wr;
  tval_t       edit;
  logic [39:0] codes;
  tval_t       new_t;

  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_op_q   <= s_axis_tuser_i;
      in_data_q <= s_axis_tdata_i;
    end
  end

  acsc_state u_state (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (adv),
    .opcode_i       (in_op_q),
    .key_i          (in_data_q[1:0]),
    .rtc_hour_bcd_i (in_data_q[7:2]),
    .rtc_min_bcd_i  (in_data_q[14:8]),
    .rtc_sec_bcd_i  (in_data_q[21:15]),
    .view_o         (view),
    .beep_o         (beep),
    .wr_o           (wr),
    .edit_o         (edit)
  );

  acsc_disp u_disp (
    .view_i  (view),
    .codes_o (codes)
  );

  assign new_t      = wr ? edit : '0;
  assign out_data_d = {6'd0, new_t[2], new_t[1], new_t[0][4:0], beep, codes};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
      out_wr_q   <= wr;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_wr_q;

  // A processed event always lands in the result register.
  a_result_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> m_axis_tvalid_o)
    else $error("processed event did not reach the result register");

  // A held input word is never dropped while the output stalls.
  a_input_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q)
    else $error("input word lost while stalled");

  // Writing the time out always goes with the return to show mode.
  a_write_leaves_edit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && wr |-> view.mode == MODE_SHOW)
    else $error("time write without leaving edit mode");

endmodule
